// ===== src/abi_pkg.sv =====
// ---------------------------------------------------------------------------
// abi_pkg
// Shared widths, constants and helpers for the Adler-32 bucket index core.
// ---------------------------------------------------------------------------
package abi_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned HASH_W     = 32;
    localparam int unsigned INDEX_W    = 24;
    localparam int unsigned IBITS_W    = 5;
    localparam int unsigned HIGH_SHIFT = 16;
    localparam int unsigned FOLD_SHIFT = 12;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [SUM_W:0]     t_sum_ext;
    typedef logic [HASH_W-1:0]  t_hash;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [IBITS_W-1:0] t_ibits;

    localparam t_sum_ext ADLER_MOD      = t_sum_ext'(65521);
    localparam t_sum     SUM_LOW_INIT   = t_sum'(1);
    localparam t_sum     SUM_HIGH_INIT  = t_sum'(0);
    localparam t_ibits   MAX_INDEX_BITS = t_ibits'(INDEX_W);
    localparam t_ibits   IBITS_RESET    = t_ibits'(10);

    // One modular add: both operands below the modulus, one subtract fixes it
    function automatic t_sum mod_add(input t_sum a, input t_sum b);
        t_sum_ext s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ADLER_MOD) begin
            s = s - ADLER_MOD;
        end
        return s[SUM_W-1:0];
    endfunction

    // Mask of the low index bits, width clamped to the index field
    function automatic t_index index_mask(input t_ibits bits);
        t_ibits             n;
        logic [INDEX_W:0]   m;
        n = (bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : bits;
        m = ({{INDEX_W{1'b0}}, 1'b1} << n) - 1'b1;
        return m[INDEX_W-1:0];
    endfunction

endpackage

// ===== src/abi_if.sv =====
// ---------------------------------------------------------------------------
// abi_key_if / abi_res_if
// Valid/ready channels for key bytes in and hash results out.
// ---------------------------------------------------------------------------
interface abi_key_if;
    logic             valid;
    logic             ready;
    abi_pkg::t_byte   key_byte;
    logic             last;

    modport source (output valid, output key_byte, output last, input ready);
    modport sink   (input valid, input key_byte, input last, output ready);
endinterface

interface abi_res_if;
    logic             valid;
    logic             ready;
    abi_pkg::t_hash   hash_value;
    abi_pkg::t_index  bucket_index;

    modport source (output valid, output hash_value, output bucket_index, input ready);
    modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

// ===== src/adler32_bucket_index_core.sv =====
// ---------------------------------------------------------------------------
// adler32_bucket_index_core
// Running Adler-32 over key bytes with a folded, masked bucket index.
// ---------------------------------------------------------------------------
// Takes one key byte per word and sustains one word per cycle, except that a
// last word waits while the result register holds a word the sink does not
// take. Each word is first captured in an input register; when it leaves that
// register the two modular sums are updated and, on a word marked last, the
// hash and bucket index land in the result register. The sum update is two
// chained 16-bit adds, each with one compare and subtract against 65521. A
// zero byte ends the key; later bytes are skipped until the last word. Sums
// return to A=1, B=0 after every last word. index_bits above 24 acts as 24.
// ---------------------------------------------------------------------------
module adler32_bucket_index_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  abi_pkg::t_ibits        i_cfg_data,
    abi_key_if.sink                i_key,
    abi_res_if.source              o_res
);

    // Configuration
    abi_pkg::t_ibits r_index_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= abi_pkg::IBITS_RESET;
        end else if (i_cfg_we) begin
            r_index_bits <= i_cfg_data;
        end
    end

    // Input stage
    logic            r_s1_valid;
    abi_pkg::t_byte  r_s1_byte;
    logic            r_s1_last;
    logic            s1_go;
    logic            in_take;

    logic            r_out_valid;
    abi_pkg::t_hash  r_hash;
    abi_pkg::t_index r_bucket;

    // A non-last word never needs the result register
    assign s1_go       = r_s1_valid && (!r_s1_last || !r_out_valid || o_res.ready);
    assign i_key.ready = !r_s1_valid || s1_go;
    assign in_take     = i_key.valid && i_key.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_key.key_byte;
            r_s1_last <= i_key.last;
        end
    end

    // Sum update
    abi_pkg::t_sum   r_sum_low;
    abi_pkg::t_sum   r_sum_high;
    logic            r_key_ended;
    abi_pkg::t_sum   add_low;
    abi_pkg::t_sum   add_high;
    logic            do_add;
    abi_pkg::t_sum   n_sum_low;
    abi_pkg::t_sum   n_sum_high;
    abi_pkg::t_hash  hash;
    abi_pkg::t_hash  folded;
    logic            res_load;

    assign add_low  = abi_pkg::mod_add(r_sum_low, {{(abi_pkg::SUM_W-abi_pkg::BYTE_W){1'b0}},
                                                   r_s1_byte});
    assign add_high = abi_pkg::mod_add(r_sum_high, add_low);
    assign do_add   = !r_key_ended && (r_s1_byte != '0);

    assign n_sum_low  = do_add ? add_low  : r_sum_low;
    assign n_sum_high = do_add ? add_high : r_sum_high;

    assign hash     = {n_sum_high, n_sum_low};
    assign folded   = hash ^ (hash >> abi_pkg::FOLD_SHIFT);
    assign res_load = s1_go && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_low   <= abi_pkg::SUM_LOW_INIT;
            r_sum_high  <= abi_pkg::SUM_HIGH_INIT;
            r_key_ended <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_sum_low   <= abi_pkg::SUM_LOW_INIT;
                r_sum_high  <= abi_pkg::SUM_HIGH_INIT;
                r_key_ended <= 1'b0;
            end else begin
                r_sum_low   <= n_sum_low;
                r_sum_high  <= n_sum_high;
                r_key_ended <= r_key_ended || (r_s1_byte == '0);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_hash   <= hash;
            r_bucket <= folded[abi_pkg::INDEX_W-1:0] & abi_pkg::index_mask(r_index_bits);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.hash_value   = r_hash;
    assign o_res.bucket_index = r_bucket;

    // Checks
    a_sums_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_sum_low} < abi_pkg::ADLER_MOD) && ({1'b0, r_sum_high} < abi_pkg::ADLER_MOD))
        else $error("Adler sum out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> (r_sum_low == abi_pkg::SUM_LOW_INIT) &&
                     (r_sum_high == abi_pkg::SUM_HIGH_INIT) && !r_key_ended)
        else $error("sums not cleared after last word");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last))
        else $error("stalled input stage lost its word");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> !$past(res_load) || r_out_valid)
        else $error("result register dropped a word");

endmodule
